@@ hw/rtl/hlv_pkg.sv @@
// ----------------------------------------------------------------------------
// hlv_pkg
// Types, constants and angle tables for the Hough line vote and peak finder.
// ----------------------------------------------------------------------------
package hlv_pkg;

    localparam int NUM_ANGLES = 256;
    localparam int ANG_W      = 8;
    localparam int NUM_RHO    = 1024;
    localparam int RHO_W      = 10;
    localparam int MAX_DIM    = 512;
    localparam int POS_W      = 9;
    localparam int DIM_W      = 10;
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 16;
    localparam int RECIP_W    = 16;
    localparam int RAD_W      = 2;
    localparam int ADDR_W     = RHO_W + ANG_W;
    localparam int ACC_SIZE   = NUM_RHO * NUM_ANGLES;
    localparam int ROM_W      = 16;
    localparam int SUM_W      = 26;
    localparam int PROD_W     = 43;
    localparam int FRAC_SH    = 26;
    localparam int RND_W      = PROD_W - FRAC_SH;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DAT_W  = 16;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH     = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_RECIP     = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_RADIUS    = 3'd4
    } cfg_reg_e;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_VOTE,
        PH_STOP
    } walk_phase_e;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_VOTE,
        BK_DRAIN,
        BK_BLK_INIT,
        BK_SCAN_RD,
        BK_SCAN_CMP,
        BK_JUDGE,
        BK_NBR_RD,
        BK_NBR_CMP,
        BK_KEEP,
        BK_NEXT_BLK,
        BK_EMIT_RD,
        BK_EMIT_LD,
        BK_NONE
    } bk_state_e;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [RECIP_W-1:0] recip;
        logic [CNT_W-1:0]   threshold;
        logic [RAD_W-1:0]   radius;
    } cfg_t;

    typedef struct packed {
        logic             is_edge;
        logic             eof;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } cmd_t;

    typedef logic signed [ROM_W-1:0] rom_t [NUM_ANGLES];

    function automatic logic [31:0] sin_cos_q14(longint unsigned phi);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned v;
        longint unsigned cq;
        longint unsigned sq;
        bit              sub;
        int              k;
        x2   = (phi * phi) >> 30;
        term = 64'd1 << 30;
        pos  = term;
        neg  = 64'd0;
        sub  = 1'b1;
        for (k = 2; k <= 20; k += 2) begin
            term = ((term * x2) >> 30) / 64'((k - 1) * k);
            if (sub) neg += term; else pos += term;
            sub = !sub;
        end
        v  = (pos > neg) ? pos - neg : 64'd0;
        cq = (v + 64'd32768) >> 16;
        if (cq > 64'd16384) cq = 64'd16384;
        term = phi;
        pos  = term;
        neg  = 64'd0;
        sub  = 1'b1;
        for (k = 3; k <= 21; k += 2) begin
            term = ((term * x2) >> 30) / 64'((k - 1) * k);
            if (sub) neg += term; else pos += term;
            sub = !sub;
        end
        v  = (pos > neg) ? pos - neg : 64'd0;
        sq = (v + 64'd32768) >> 16;
        if (sq > 64'd16384) sq = 64'd16384;
        return {sq[15:0], cq[15:0]};
    endfunction

    // x table holds sin(a), y table -cos(a), a = n*(3*pi/2)/NUM_ANGLES
    function automatic rom_t build_rom(bit want_y);
        rom_t                    r;
        int                      n;
        int                      t;
        int                      quad;
        int                      frac;
        longint unsigned         phi;
        logic [31:0]             sc;
        logic signed [ROM_W-1:0] s;
        logic signed [ROM_W-1:0] c;
        for (n = 0; n < NUM_ANGLES; n++) begin
            t    = 3 * n;
            quad = t / NUM_ANGLES;
            frac = t % NUM_ANGLES;
            phi  = 64'(frac) * HALF_PI_Q30 / NUM_ANGLES;
            sc   = sin_cos_q14(phi);
            s    = signed'(sc[31:16]);
            c    = signed'(sc[15:0]);
            if (quad == 0) r[n] = want_y ? -c : s;
            else if (quad == 1) r[n] = want_y ? s : c;
            else r[n] = want_y ? c : -s;
        end
        return r;
    endfunction

    localparam rom_t ROM_X = build_rom(1'b0);
    localparam rom_t ROM_Y = build_rom(1'b1);

endpackage

@@ hw/rtl/hlv_pix_if.sv @@
// ----------------------------------------------------------------------------
// hlv_pix_if
// Pixel input channel.
// ----------------------------------------------------------------------------
interface hlv_pix_if import hlv_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

@@ hw/rtl/hlv_cfg_if.sv @@
// ----------------------------------------------------------------------------
// hlv_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface hlv_cfg_if import hlv_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/hlv_res_if.sv @@
// ----------------------------------------------------------------------------
// hlv_res_if
// Peak result channel.
// ----------------------------------------------------------------------------
interface hlv_res_if import hlv_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [RHO_W-1:0] rho_index;
    logic [ANG_W-1:0] angle_index;
    logic [CNT_W-1:0] votes;
    logic             found;
    logic             overflow;
    logic             last;

    modport source (output valid, output rho_index, output angle_index, output votes,
                    output found, output overflow, output last, input ready);
    modport sink (input valid, input rho_index, input angle_index, input votes,
                  input found, input overflow, input last, output ready);
endinterface

@@ hw/rtl/hlv_front.sv @@
// ----------------------------------------------------------------------------
// hlv_front
// Config registers, pixel position counters and command classification.
// ----------------------------------------------------------------------------
module hlv_front import hlv_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    hlv_pix_if.sink pix,
    hlv_cfg_if.sink cfg_ch,
    input  logic  init_done,
    input  logic  q_ready,
    output logic  q_push,
    output cmd_t  q_cmd,
    output cfg_t  cfg
);

    cfg_t             cfg_reg;
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] row_next;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             col_last;
    logic             row_last;

    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    always_comb
    begin
        if (cfg_reg.width == '0) w_eff = DIM_W'(1);
        else if (cfg_reg.width > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
        else w_eff = cfg_reg.width;
        if (cfg_reg.height == '0) h_eff = DIM_W'(1);
        else if (cfg_reg.height > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
        else h_eff = cfg_reg.height;
    end

    assign col_last = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign row_last = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;

    assign pix.ready = init_done && q_ready;
    assign q_push    = pix.valid && pix.ready;

    always_comb
    begin
        q_cmd.is_edge = (pix.pixel_value != '0);
        q_cmd.eof     = col_last && row_last;
        q_cmd.x       = col_reg;
        q_cmd.y       = row_reg;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (!col_last)
            begin
                col_next = col_reg + POS_W'(1);
            end
            else
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg           <= '0;
            row_reg           <= '0;
            cfg_reg.width     <= DIM_W'(320);
            cfg_reg.height    <= DIM_W'(240);
            cfg_reg.recip     <= RECIP_W'(4096);
            cfg_reg.threshold <= CNT_W'(100);
            cfg_reg.radius    <= RAD_W'(2);
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_ch.valid)
            begin
                unique case (cfg_reg_e'(cfg_ch.index))
                    REG_WIDTH:     cfg_reg.width     <= cfg_ch.data[DIM_W-1:0];
                    REG_HEIGHT:    cfg_reg.height    <= cfg_ch.data[DIM_W-1:0];
                    REG_RECIP:     cfg_reg.recip     <= cfg_ch.data[RECIP_W-1:0];
                    REG_THRESHOLD: cfg_reg.threshold <= cfg_ch.data[CNT_W-1:0];
                    REG_RADIUS:    cfg_reg.radius    <= cfg_ch.data[RAD_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/hlv_fifo.sv @@
// ----------------------------------------------------------------------------
// hlv_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module hlv_fifo import hlv_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + (FIFO_AW+1)'(1);
        else if (pop && !push) count_next = count_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop) rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ hw/rtl/hlv_back.sv @@
// ----------------------------------------------------------------------------
// hlv_back
// Vote pipeline, accumulator store, peak search, result output and clearing.
// ----------------------------------------------------------------------------
module hlv_back import hlv_pkg::*; #(
    parameter int MAX_PEAKS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic init_done,
    hlv_res_if.source res
);

    localparam int PK_AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int PK_CW = $clog2(MAX_PEAKS + 1);
    localparam int PK_DW = RHO_W + ANG_W + CNT_W;

    bk_state_e state_reg;
    bk_state_e state_next;
    cmd_t      cmd_reg;
    logic      init_done_reg;

    // vote pipeline
    logic [ANG_W-1:0]        n_reg;
    logic                    a_v_reg;
    logic                    b_v_reg;
    logic                    c_v_reg;
    logic                    d_v_reg;
    logic                    f_v_reg;
    logic [ANG_W-1:0]        a_n_reg;
    logic [ANG_W-1:0]        b_n_reg;
    logic [ANG_W-1:0]        c_n_reg;
    logic [ANG_W-1:0]        d_n_reg;
    logic signed [SUM_W-1:0] a_px_reg;
    logic signed [SUM_W-1:0] a_py_reg;
    logic signed [SUM_W-1:0] b_sum_reg;
    logic signed [PROD_W-1:0] c_prod_reg;
    logic                    d_neg_reg;
    logic                    d_inr_reg;
    logic [RHO_W-1:0]        d_r_reg;
    logic [ADDR_W-1:0]       f_addr_reg;
    walk_phase_e             phase_reg;

    logic signed [SUM_W-1:0]  xw;
    logic signed [SUM_W-1:0]  yw;
    logic signed [SUM_W-1:0]  cxw;
    logic signed [SUM_W-1:0]  syw;
    logic signed [PROD_W-1:0] sw;
    logic signed [PROD_W-1:0] rw;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        rnd_full;
    logic [RND_W-1:0]         rnd;
    logic                     vote_rd;
    logic                     pipe_busy;

    // accumulator store
    logic [CNT_W-1:0]  acc_mem [ACC_SIZE];
    logic [CNT_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic [ADDR_W-1:0] clr_reg;

    // peak search
    logic [RHO_W:0]   bi_reg;
    logic [ANG_W:0]   bj_reg;
    logic [RHO_W-1:0] ci_reg;
    logic [ANG_W-1:0] cj_reg;
    logic [RHO_W-1:0] mi_reg;
    logic [ANG_W-1:0] mj_reg;
    logic [CNT_W-1:0] mv_reg;
    logic [PK_CW-1:0] cnt_reg;
    logic [PK_CW-1:0] k_reg;
    logic             ovf_reg;
    logic [1:0]       rad;
    logic [1:0]       step;
    logic [RHO_W:0]   blk_i_last;
    logic [ANG_W:0]   blk_j_last;
    logic             i_end;
    logic             j_end;
    logic [RHO_W:0]   ihi;
    logic [ANG_W:0]   jhi;
    logic [RHO_W-1:0] i0;
    logic [RHO_W-1:0] i1;
    logic [ANG_W-1:0] j0;
    logic [ANG_W-1:0] j1;
    logic             beaten;
    logic [RHO_W:0]   bi_step;
    logic [ANG_W:0]   bj_step;
    logic             row_done;
    logic             search_done;
    logic             room;

    // peak buffer and output
    logic [PK_DW-1:0] pk_mem [MAX_PEAKS];
    logic [PK_DW-1:0] pk_rd_reg;
    logic             pk_we;
    logic             slot_free;
    logic             out_load;
    logic             out_v_reg;
    logic [RHO_W-1:0] out_rho_reg;
    logic [ANG_W-1:0] out_ang_reg;
    logic [CNT_W-1:0] out_votes_reg;
    logic             out_found_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;
    logic             emit_last;

    assign init_done = init_done_reg;

    // ---- vote arithmetic
    assign xw  = signed'(SUM_W'(cmd_reg.x));
    assign yw  = signed'(SUM_W'(cmd_reg.y));
    assign cxw = SUM_W'(ROM_X[n_reg]);
    assign syw = SUM_W'(ROM_Y[n_reg]);
    assign sw  = PROD_W'(b_sum_reg);
    assign rw  = signed'(PROD_W'(cfg.recip));

    always_comb
    begin
        mag      = c_prod_reg[PROD_W-1] ? unsigned'(-c_prod_reg) : unsigned'(c_prod_reg);
        rnd_full = (mag + (PROD_W'(1) << (FRAC_SH - 1))) >> FRAC_SH;
        rnd      = rnd_full[RND_W-1:0];
    end

    assign vote_rd   = d_v_reg && !d_neg_reg && (phase_reg != PH_STOP) && d_inr_reg;
    assign pipe_busy = a_v_reg || b_v_reg || c_v_reg || d_v_reg || f_v_reg;

    // ---- search geometry
    always_comb
    begin
        if (cfg.radius == 2'd0) rad = 2'd1;
        else if (cfg.radius == 2'd3) rad = 2'd2;
        else rad = cfg.radius;
        step = rad + 2'd1;

        blk_i_last = bi_reg + (RHO_W+1)'(step) - (RHO_W+1)'(1);
        blk_j_last = bj_reg + (ANG_W+1)'(step) - (ANG_W+1)'(1);
        i_end = ({1'b0, ci_reg} == blk_i_last) || (ci_reg == RHO_W'(NUM_RHO - 1));
        j_end = ({1'b0, cj_reg} == blk_j_last) || (cj_reg == ANG_W'(NUM_ANGLES - 1));

        i0  = (mi_reg >= RHO_W'(rad)) ? mi_reg - RHO_W'(rad) : '0;
        j0  = (mj_reg >= ANG_W'(rad)) ? mj_reg - ANG_W'(rad) : '0;
        ihi = {1'b0, mi_reg} + (RHO_W+1)'(rad);
        jhi = {1'b0, mj_reg} + (ANG_W+1)'(rad);
        i1  = (ihi < (RHO_W+1)'(NUM_RHO)) ? ihi[RHO_W-1:0] : RHO_W'(NUM_RHO - 1);
        j1  = (jhi < (ANG_W+1)'(NUM_ANGLES)) ? jhi[ANG_W-1:0] : ANG_W'(NUM_ANGLES - 1);

        beaten = !((ci_reg == mi_reg) && (cj_reg == mj_reg)) && (rd_data_reg > mv_reg);

        bi_step     = bi_reg + (RHO_W+1)'(step);
        bj_step     = bj_reg + (ANG_W+1)'(step);
        row_done    = bj_step >= (ANG_W+1)'(NUM_ANGLES);
        search_done = row_done && (bi_step >= (RHO_W+1)'(NUM_RHO));
        room        = cnt_reg < PK_CW'(MAX_PEAKS);
    end

    assign slot_free = !out_v_reg || res.ready;
    assign emit_last = (k_reg + PK_CW'(1)) == cnt_reg;

    // ---- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:    if (clr_reg == ADDR_W'(ACC_SIZE - 1)) state_next = BK_IDLE;
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_edge) state_next = BK_VOTE;
                    else if (q_cmd.eof) state_next = BK_BLK_INIT;
                end
            end
            BK_VOTE:     if (n_reg == ANG_W'(NUM_ANGLES - 1)) state_next = BK_DRAIN;
            BK_DRAIN:
            begin
                if (!pipe_busy) state_next = cmd_reg.eof ? BK_BLK_INIT : BK_IDLE;
            end
            BK_BLK_INIT: state_next = BK_SCAN_RD;
            BK_SCAN_RD:  state_next = BK_SCAN_CMP;
            BK_SCAN_CMP: state_next = (i_end && j_end) ? BK_JUDGE : BK_SCAN_RD;
            BK_JUDGE:    state_next = (mv_reg > cfg.threshold) ? BK_NBR_RD : BK_NEXT_BLK;
            BK_NBR_RD:   state_next = BK_NBR_CMP;
            BK_NBR_CMP:
            begin
                if (beaten) state_next = BK_NEXT_BLK;
                else if ((ci_reg == i1) && (cj_reg == j1)) state_next = BK_KEEP;
                else state_next = BK_NBR_RD;
            end
            BK_KEEP:     state_next = BK_NEXT_BLK;
            BK_NEXT_BLK:
            begin
                if (!search_done) state_next = BK_BLK_INIT;
                else if (cnt_reg == '0) state_next = BK_NONE;
                else state_next = BK_EMIT_RD;
            end
            BK_EMIT_RD:  state_next = BK_EMIT_LD;
            BK_EMIT_LD:
            begin
                if (slot_free) state_next = emit_last ? BK_CLEAR : BK_EMIT_RD;
            end
            BK_NONE:     if (slot_free) state_next = BK_CLEAR;
            default:     state_next = BK_IDLE;
        endcase
    end

    // ---- control outputs
    always_comb
    begin
        q_pop    = (state_reg == BK_IDLE) && q_valid;
        pk_we    = (state_reg == BK_KEEP) && room;
        out_load = ((state_reg == BK_EMIT_LD) || (state_reg == BK_NONE)) && slot_free;
        rd_addr  = vote_rd ? {d_r_reg, d_n_reg} : {ci_reg, cj_reg};
        if (state_reg == BK_CLEAR)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            mem_we  = f_v_reg;
            wr_addr = f_addr_reg;
            wr_data = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + CNT_W'(1);
        end
    end

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            init_done_reg <= 1'b0;
            clr_reg       <= '0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            d_v_reg       <= 1'b0;
            f_v_reg       <= 1'b0;
            phase_reg     <= PH_SKIP;
            n_reg         <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_v_reg   <= (state_reg == BK_VOTE);
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            d_v_reg   <= c_v_reg;
            f_v_reg   <= vote_rd;
            if (state_reg == BK_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(ACC_SIZE - 1)) init_done_reg <= 1'b1;
            end
            if (q_pop)
            begin
                phase_reg <= PH_SKIP;
                n_reg     <= '0;
                cnt_reg   <= '0;
                k_reg     <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (d_v_reg)
            begin
                if (d_neg_reg && (phase_reg == PH_VOTE)) phase_reg <= PH_STOP;
                else if (!d_neg_reg && (phase_reg == PH_SKIP)) phase_reg <= PH_VOTE;
            end
            if (state_reg == BK_VOTE) n_reg <= n_reg + ANG_W'(1);
            if (state_reg == BK_KEEP)
            begin
                if (room) cnt_reg <= cnt_reg + PK_CW'(1);
                else ovf_reg <= 1'b1;
            end
            if ((state_reg == BK_EMIT_LD) && slot_free) k_reg <= k_reg + PK_CW'(1);
            if (out_load) out_v_reg <= 1'b1;
            else if (res.ready) out_v_reg <= 1'b0;
        end
    end

    // ---- datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop) cmd_reg <= q_cmd;
        a_n_reg    <= n_reg;
        a_px_reg   <= xw * cxw;
        a_py_reg   <= yw * syw;
        b_n_reg    <= a_n_reg;
        b_sum_reg  <= a_px_reg + a_py_reg;
        c_n_reg    <= b_n_reg;
        c_prod_reg <= sw * rw;
        d_n_reg    <= c_n_reg;
        d_neg_reg  <= c_prod_reg[PROD_W-1] && (rnd != '0);
        d_inr_reg  <= rnd < RND_W'(NUM_RHO);
        d_r_reg    <= rnd[RHO_W-1:0];
        f_addr_reg <= {d_r_reg, d_n_reg};

        case (state_reg)
            BK_IDLE:
            begin
                bi_reg <= '0;
                bj_reg <= '0;
            end
            BK_BLK_INIT:
            begin
                ci_reg <= bi_reg[RHO_W-1:0];
                cj_reg <= bj_reg[ANG_W-1:0];
                mi_reg <= bi_reg[RHO_W-1:0];
                mj_reg <= bj_reg[ANG_W-1:0];
                mv_reg <= '0;
            end
            BK_SCAN_CMP:
            begin
                if (rd_data_reg > mv_reg)
                begin
                    mv_reg <= rd_data_reg;
                    mi_reg <= ci_reg;
                    mj_reg <= cj_reg;
                end
                if (j_end)
                begin
                    cj_reg <= bj_reg[ANG_W-1:0];
                    if (!i_end) ci_reg <= ci_reg + RHO_W'(1);
                end
                else
                begin
                    cj_reg <= cj_reg + ANG_W'(1);
                end
            end
            BK_JUDGE:
            begin
                ci_reg <= i0;
                cj_reg <= j0;
            end
            BK_NBR_CMP:
            begin
                if (cj_reg == j1)
                begin
                    cj_reg <= j0;
                    ci_reg <= ci_reg + RHO_W'(1);
                end
                else
                begin
                    cj_reg <= cj_reg + ANG_W'(1);
                end
            end
            BK_NEXT_BLK:
            begin
                if (row_done)
                begin
                    bj_reg <= '0;
                    bi_reg <= bi_step;
                end
                else
                begin
                    bj_reg <= bj_step;
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            if (state_reg == BK_NONE)
            begin
                out_rho_reg   <= '0;
                out_ang_reg   <= '0;
                out_votes_reg <= '0;
                out_found_reg <= 1'b0;
                out_ovf_reg   <= 1'b0;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                {out_rho_reg, out_ang_reg, out_votes_reg} <= pk_rd_reg;
                out_found_reg <= 1'b1;
                out_ovf_reg   <= ovf_reg;
                out_last_reg  <= emit_last;
            end
        end
    end

    // ---- memories
    always_ff @(posedge clk)
    begin
        if (mem_we) acc_mem[wr_addr] <= wr_data;
        rd_data_reg <= acc_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pk_we) pk_mem[cnt_reg[PK_AW-1:0]] <= {mi_reg, mj_reg, mv_reg};
        pk_rd_reg <= pk_mem[k_reg[PK_AW-1:0]];
    end

    assign res.valid       = out_v_reg;
    assign res.rho_index   = out_rho_reg;
    assign res.angle_index = out_ang_reg;
    assign res.votes       = out_votes_reg;
    assign res.found       = out_found_reg;
    assign res.overflow    = out_ovf_reg;
    assign res.last        = out_last_reg;

endmodule

@@ hw/rtl/hough_line_vote_and_peak_find.sv @@
// ----------------------------------------------------------------------------
// hough_line_vote_and_peak_find
// Hough line voting over raster edge pixels with block peak search per frame.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  pix      in   one raster pixel (pixel_value)
//  cfg      in   register write (index, data)
//  res      out  one peak (rho_index, angle_index, votes, found, overflow, last)
//
//  Zero pixel: dropped by the back end unless it ends the frame. Edge pixel: an
//  accumulator read-modify-write for each angle of its first run of non-negative rho
//  that lands in range, through the vote pipeline (a, b, c, d, f). Frame end: block
//  search by store reads and compares, peaks out one by one, then a clear of the whole
//  store over the single write port. After reset the same clear runs with pix held not ready.
//  A 4-deep command queue lets pixels arrive while the back end works.
// ----------------------------------------------------------------------------
module hough_line_vote_and_peak_find import hlv_pkg::*; #(
    parameter int MAX_PEAKS = 64
) (
    input logic clk,
    input logic rst_n,
    hlv_pix_if.sink pix,
    hlv_cfg_if.sink cfg,
    hlv_res_if.source res
);

    cfg_t cfg_val;
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic q_push;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    logic init_done;

    hlv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .cfg_ch    (cfg),
        .init_done (init_done),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .cfg       (cfg_val)
    );

    hlv_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (pop_cmd)
    );

    hlv_back #(
        .MAX_PEAKS (MAX_PEAKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_val),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .init_done (init_done),
        .res       (res)
    );

    a_no_pix_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> !pix.ready)
        else $error("pixel taken during store clear");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("queue push while full");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    a_no_peak_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.found |-> res.last && !res.overflow)
        else $error("empty result not final");

    a_result_after_init: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> init_done)
        else $error("result before store clear finished");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Hough line vote and peak finder. Pixels go in
// as small frames, and each pixel is folded into a local vote store as it is
// accepted. At the end of a frame the expected peak list is built from that
// store. Every beat on the result channel is checked against it in order.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_top import hlv_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [RHO_W-1:0] rho;
        bit [ANG_W-1:0] ang;
        bit [CNT_W-1:0] votes;
        bit             found;
        bit             ovf;
        bit             last;
    } peak_t;

    localparam int PEAK_CAP  = 64;
    localparam int LONG_HOLD = 4000;

    logic clk;
    logic rst_n;

    hlv_pix_if pix ();
    hlv_cfg_if cfg ();
    hlv_res_if res ();

    hough_line_vote_and_peak_find #(.MAX_PEAKS(PEAK_CAP)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg),
        .res   (res)
    );

    bit [CNT_W-1:0]     vote_store [ACC_SIZE];
    int                 col_pos;
    int                 row_pos;
    logic [DIM_W-1:0]   sh_width;
    logic [DIM_W-1:0]   sh_height;
    logic [RECIP_W-1:0] sh_recip;
    logic [CNT_W-1:0]   sh_threshold;
    logic [RAD_W-1:0]   sh_radius;

    peak_t peak_q[$];
    int    fails;
    int    pix_gap_max;
    int    res_gap_max;
    bit    hold_armed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd400_000_000);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint rho_of(int x, int y, int n);
        longint v;
        longint half;
        half = longint'(1) << 25;
        v = (longint'(x) * longint'(ROM_X[n]) + longint'(y) * longint'(ROM_Y[n]))
            * longint'({1'b0, sh_recip});
        if (v >= 0)
            return (v + half) >>> 26;
        return -((-v + half) >>> 26);
    endfunction

    function automatic void cast_votes(int x, int y);
        int     n;
        int     a;
        longint r;
        n = 0;
        while (n < NUM_ANGLES && rho_of(x, y, n) < 0)
            n++;
        while (n < NUM_ANGLES)
        begin
            r = rho_of(x, y, n);
            if (r < 0)
                break;
            if (r < NUM_RHO)
            begin
                a = int'(r) * NUM_ANGLES + n;
                if (vote_store[a] != 16'hFFFF)
                    vote_store[a]++;
            end
            n++;
        end
    endfunction

    function automatic void find_peaks();
        int    rad;
        int    step;
        int    mi;
        int    mj;
        int    mv;
        int    ie;
        int    je;
        int    i0;
        int    i1;
        int    j0;
        int    j1;
        bit    beaten;
        bit    ovf;
        peak_t p;
        peak_t frame_q[$];
        rad  = (sh_radius < 1) ? 1 : ((sh_radius > 2) ? 2 : int'(sh_radius));
        step = rad + 1;
        ovf  = 1'b0;
        for (int bi = 0; bi < NUM_RHO; bi += step)
        begin
            for (int bj = 0; bj < NUM_ANGLES; bj += step)
            begin
                mi = bi;
                mj = bj;
                mv = int'(vote_store[bi * NUM_ANGLES + bj]);
                ie = (bi + step < NUM_RHO) ? bi + step : NUM_RHO;
                je = (bj + step < NUM_ANGLES) ? bj + step : NUM_ANGLES;
                for (int i = bi; i < ie; i++)
                    for (int j = bj; j < je; j++)
                        if (vote_store[i * NUM_ANGLES + j] > mv)
                        begin
                            mv = int'(vote_store[i * NUM_ANGLES + j]);
                            mi = i;
                            mj = j;
                        end
                if (mv <= int'(sh_threshold))
                    continue;
                i0 = (mi >= rad) ? mi - rad : 0;
                i1 = (mi + rad < NUM_RHO) ? mi + rad : NUM_RHO - 1;
                j0 = (mj >= rad) ? mj - rad : 0;
                j1 = (mj + rad < NUM_ANGLES) ? mj + rad : NUM_ANGLES - 1;
                beaten = 1'b0;
                for (int i = i0; i <= i1; i++)
                    for (int j = j0; j <= j1; j++)
                        if ((i != mi || j != mj) && vote_store[i * NUM_ANGLES + j] > mv)
                            beaten = 1'b1;
                if (beaten)
                    continue;
                if (frame_q.size() < PEAK_CAP)
                begin
                    p.rho   = RHO_W'(mi);
                    p.ang   = ANG_W'(mj);
                    p.votes = CNT_W'(mv);
                    p.found = 1'b1;
                    p.ovf   = 1'b0;
                    p.last  = 1'b0;
                    frame_q = {frame_q, p};
                end
                else
                    ovf = 1'b1;
            end
        end
        if (frame_q.size() == 0)
        begin
            p = '{rho: '0, ang: '0, votes: '0, found: 1'b0, ovf: 1'b0, last: 1'b1};
            peak_q = {peak_q, p};
            return;
        end
        foreach (frame_q[k])
        begin
            p      = frame_q[k];
            p.ovf  = ovf;
            p.last = (k == frame_q.size() - 1);
            peak_q = {peak_q, p};
        end
    endfunction

    function automatic void predict_pixel(logic [PIX_W-1:0] v);
        int w;
        int h;
        w = (sh_width == 0) ? 1 : ((sh_width > MAX_DIM) ? MAX_DIM : int'(sh_width));
        h = (sh_height == 0) ? 1 : ((sh_height > MAX_DIM) ? MAX_DIM : int'(sh_height));
        if (v != 0)
            cast_votes(col_pos, row_pos);
        if (col_pos + 1 < w)
        begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < h)
        begin
            row_pos++;
            return;
        end
        row_pos = 0;
        find_peaks();
        for (int a = 0; a < ACC_SIZE; a++)
            vote_store[a] = '0;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_WIDTH:     sh_width     = value[DIM_W-1:0];
            REG_HEIGHT:    sh_height    = value[DIM_W-1:0];
            REG_RECIP:     sh_recip     = value[RECIP_W-1:0];
            REG_THRESHOLD: sh_threshold = value[CNT_W-1:0];
            REG_RADIUS:    sh_radius    = value[RAD_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] v);
        int n;
        n = $urandom_range(0, pix_gap_max);
        @(negedge clk);
        if (n > 0)
        begin
            pix.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_value <= v;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        predict_pixel(v);
    endtask

    task automatic pix_idle();
        @(negedge clk);
        pix.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (peak_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        if ($urandom_range(0, 9) < 6)
            return '0;
        return PIX_W'($urandom_range(1, 255));
    endfunction

    task automatic send_frame(int w, int h);
        for (int i = 0; i < w * h; i++)
            send_pixel(rand_pixel());
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_armed)
            begin
                res.ready <= 1'b0;
                do @(posedge clk); while (!res.valid);
                hold_armed = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                res.ready <= 1'b1;
            end
            else
            begin
                n = $urandom_range(0, res_gap_max);
                if (n > 0)
                begin
                    res.ready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
                res.ready <= 1'b1;
            end
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
        end
    end

    function automatic void check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        peak_t p;
        if (rst_n && res.valid && res.ready)
        begin
            if (peak_q.size() == 0)
            begin
                $error("result beat with no peak expected");
                fails++;
            end
            else
            begin
                p = peak_q.pop_front();
                check_field("rho_index", int'(p.rho), int'(res.rho_index));
                check_field("angle_index", int'(p.ang), int'(res.angle_index));
                check_field("votes", int'(p.votes), int'(res.votes));
                check_field("found", int'(p.found), int'(res.found));
                check_field("overflow", int'(p.ovf), int'(res.overflow));
                check_field("last", int'(p.last), int'(res.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // pixel at the origin votes bin 0 on every angle: overflow of the peak list
    task automatic test_single_edge();
        pix_gap_max = 0;
        res_gap_max = 0;
        write_reg(REG_WIDTH, CFG_DAT_W'(0));
        write_reg(REG_HEIGHT, CFG_DAT_W'(0));
        write_reg(REG_RECIP, CFG_DAT_W'(4096));
        write_reg(REG_THRESHOLD, CFG_DAT_W'(0));
        write_reg(REG_RADIUS, CFG_DAT_W'(0));
        send_pixel(8'hFF);
        pix_idle();
        wait_drained();
    endtask

    task automatic test_no_peak();
        pix_gap_max = 12;
        res_gap_max = 12;
        write_reg(REG_WIDTH, CFG_DAT_W'(2));
        write_reg(REG_HEIGHT, CFG_DAT_W'(1));
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_RADIUS, CFG_DAT_W'(3));
        send_pixel(8'h01);
        send_pixel(8'h80);
        pix_idle();
        wait_drained();
    endtask

    task automatic test_zero_recip();
        write_reg(REG_RECIP, CFG_DAT_W'(0));
        write_reg(REG_THRESHOLD, CFG_DAT_W'(1));
        write_reg(REG_RADIUS, CFG_DAT_W'(2));
        write_reg(REG_WIDTH, CFG_DAT_W'(3));
        write_reg(REG_HEIGHT, CFG_DAT_W'(2));
        send_pixel(8'h55);
        send_pixel(8'hAA);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h0F);
        send_pixel(8'hF0);
        pix_idle();
        wait_drained();
    endtask

    // large recip pushes far columns past the last rho bin; width shrinks mid-frame
    task automatic test_far_rho();
        pix_gap_max = 3;
        write_reg(REG_RECIP, 16'hFFFF);
        write_reg(REG_THRESHOLD, CFG_DAT_W'(0));
        write_reg(REG_RADIUS, CFG_DAT_W'(1));
        write_reg(REG_WIDTH, CFG_DAT_W'(72));
        write_reg(REG_HEIGHT, CFG_DAT_W'(2));
        for (int i = 0; i < 77; i++)
            send_pixel((i >= 64 && i < 72) || i == 0 || i == 76 ?
                       PIX_W'($urandom_range(1, 255)) : PIX_W'(0));
        pix_idle();
        repeat (4000) @(posedge clk);
        write_reg(REG_WIDTH, CFG_DAT_W'(3));
        send_pixel(8'h01);
        pix_idle();
        wait_drained();
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        repeat (2)
        begin
            w = $urandom_range(8, 14);
            h = $urandom_range(6, 9);
            pix_gap_max = $urandom_range(0, 1) ? 12 : 0;
            res_gap_max = $urandom_range(0, 1) ? 12 : 0;
            write_reg(REG_WIDTH, CFG_DAT_W'(w));
            write_reg(REG_HEIGHT, CFG_DAT_W'(h));
            write_reg(REG_RECIP, ($urandom_range(0, 3) == 0) ?
                      CFG_DAT_W'($urandom_range(256, 65535)) :
                      CFG_DAT_W'($urandom_range(2048, 8192)));
            write_reg(REG_THRESHOLD, CFG_DAT_W'($urandom_range(0, 4)));
            write_reg(REG_RADIUS, CFG_DAT_W'($urandom_range(1, 2)));
            send_frame(w, h);
            pix_idle();
            wait_drained();
        end
    endtask

    // results stall while the next frame is offered at full rate
    task automatic test_backpressure();
        int w;
        int h;
        w = $urandom_range(6, 10);
        h = $urandom_range(5, 8);
        pix_gap_max = 0;
        res_gap_max = 6;
        write_reg(REG_WIDTH, CFG_DAT_W'(w));
        write_reg(REG_HEIGHT, CFG_DAT_W'(h));
        write_reg(REG_RECIP, CFG_DAT_W'($urandom_range(3000, 6000)));
        write_reg(REG_THRESHOLD, CFG_DAT_W'(1));
        write_reg(REG_RADIUS, CFG_DAT_W'(2));
        hold_armed = 1'b1;
        send_frame(w, h);
        send_frame(w, h);
        pix_idle();
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        pix.valid       = 1'b0;
        pix.pixel_value = '0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_WIDTH;
        cfg.data        = '0;
        fails           = 0;
        hold_armed      = 1'b0;
        pix_gap_max     = 0;
        res_gap_max     = 0;
        col_pos         = 0;
        row_pos         = 0;
        sh_width        = DIM_W'(320);
        sh_height       = DIM_W'(240);
        sh_recip        = RECIP_W'(4096);
        sh_threshold    = CNT_W'(100);
        sh_radius       = RAD_W'(2);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_edge();
        test_no_peak();
        test_zero_recip();
        test_far_rho();
        test_random_frames();
        test_backpressure();

        wait_drained();
        repeat (2000) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/hlv_pkg.sv
hw/rtl/hlv_pix_if.sv
hw/rtl/hlv_cfg_if.sv
hw/rtl/hlv_res_if.sv
hw/rtl/hlv_front.sv
hw/rtl/hlv_fifo.sv
hw/rtl/hlv_back.sv
hw/rtl/hough_line_vote_and_peak_find.sv
sim/tb_top.sv
